FILE: hdl/alp_pkg.sv
// Package for the audio level to PWM unit: shared widths, reset constants,
// status struct and the elaboration-time fixed-point log2 used to build the ROM.
// No dependencies.
package alp_pkg;

  // Widths of the payload fields.
  localparam int unsigned SampleW = 12;
  localparam int unsigned LevelW  = 16;
  localparam int unsigned ThreshW = 12;

  // Default build values.
  localparam int unsigned CalSamplesDef   = 5000;
  localparam int unsigned MaxLevelDiffDef = 2000;

  localparam logic [ThreshW-1:0] ThresholdReset = ThreshW'(1000);
  localparam logic [LevelW-1:0]  FullScale      = {LevelW{1'b1}};

  // Fraction bits of the fixed-point logarithm.
  localparam int unsigned LogFrac = 44;

  // Calibration status handed from the calibration unit to the top level.
  typedef struct packed {
    logic               done;      // baseline is valid
    logic               busy;      // baseline division in progress
    logic [SampleW-1:0] baseline;
  } cal_status_t;

  // Squares a Q1.62 value and returns the product in Q62, truncated.
  function automatic logic [63:0] alp_square_q62(input logic [63:0] y);
    logic [127:0] prod;
    prod = {64'd0, y} * {64'd0, y};
    return prod[125:62];
  endfunction

  // Base-2 logarithm of x in unsigned fixed point with LogFrac fraction bits.
  function automatic logic [63:0] alp_log2_fixed(input logic [31:0] x);
    logic [31:0] xv;
    logic [5:0]  n;
    logic [63:0] y;
    logic [63:0] acc;
    xv = (x == 32'd0) ? 32'd1 : x;
    n  = 6'd0;
    for (int k = 0; k < 31; k++) begin
      if ((xv >> (n + 6'd1)) != 32'd0) begin
        n = n + 6'd1;
      end
    end
    y   = {32'd0, xv} << (6'd62 - n);
    acc = {58'd0, n} << LogFrac;
    for (int i = LogFrac - 1; i >= 0; i--) begin
      y = alp_square_q62(y);
      if (y[63]) begin
        y      = y >> 1;
        acc[i] = 1'b1;
      end
    end
    return acc;
  endfunction

  // Restoring shift-subtract division; returns {quotient, remainder}.
  function automatic logic [127:0] alp_udiv64(input logic [63:0] num,
                                              input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = 65'd0;
    quo = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return {quo, rem[63:0]};
  endfunction

endpackage

FILE: hdl/alp_if.sv
// Stream and configuration channel interfaces of the audio level to PWM unit.
// Depends on alp_pkg for the field widths.
interface alp_sample_if import alp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface alp_result_if import alp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] pwm_level;
  logic [LevelW-1:0] instant_brightness;

  modport source (output valid, output pwm_level, output instant_brightness, input ready);
  modport sink   (input valid, input pwm_level, input instant_brightness, output ready);
endinterface

interface alp_cfg_if import alp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ThreshW-1:0] excess_limit;

  modport source (output valid, output excess_limit, input ready);
  modport sink   (input valid, input excess_limit, output ready);
endinterface

FILE: hdl/audio_level_to_pwm_unit.sv
// Top level of the audio level to PWM unit: threshold register, level gating,
// three-stage result pipeline and smoothing. Depends on alp_pkg, alp_if,
// alp_calib and alp_log_rom.
//
//   channel     | dir | payload                          | handshake
//   ------------+-----+----------------------------------+-------------
//   sample_in   | in  | sample[11:0]                     | valid/ready
//   result_out  | out | pwm_level[15:0], instant_bright. | valid/ready
//   cfg_in      | in  | excess_limit[11:0]               | valid/ready
//
// After calibration a sample is taken every cycle unless a stalled result has filled the
// pipeline. A transfer loads the level register; the value then moves through the ROM read
// register to the output register, which presents the result. The first CAL_SAMPLES
// samples produce no result; the transfer that completes them is followed by the CAL_DIV
// state, in which the baseline is formed by a reciprocal multiplication while
// sample_in.ready stays low.
// Reset clears calibration, the smoothing state and all valid bits, and loads the
// threshold with 1000. Each stage moves forward when the stage after it is empty
// or moving, so a stalled result does not block samples until the pipeline fills.
module audio_level_to_pwm_unit import alp_pkg::*; #(
  parameter int unsigned CAL_SAMPLES    = CalSamplesDef,
  parameter int unsigned MAX_LEVEL_DIFF = MaxLevelDiffDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  alp_sample_if.sink  sample_in,
  alp_result_if.source result_out,
  alp_cfg_if.sink     cfg_in
);

  localparam int unsigned DiffW = $clog2(MAX_LEVEL_DIFF + 1);
  localparam logic [SampleW-1:0] MaxDiff = SampleW'(MAX_LEVEL_DIFF);

  // Configuration: the threshold register is always ready for a transfer.
  logic [ThreshW-1:0] thresh_q;

  assign cfg_in.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThresholdReset;
    end else if (cfg_in.valid) begin
      thresh_q <= cfg_in.excess_limit;
    end
  end

  // Pipeline flow control. Each stage advances when it is empty or its
  // successor advances.
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;
  logic in_xfer, cal_xfer, pipe_xfer;
  cal_status_t cal_status;

  assign adv3 = !v3_q || result_out.ready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign sample_in.ready = adv1 && !cal_status.busy;
  assign in_xfer   = sample_in.valid && sample_in.ready;
  assign cal_xfer  = in_xfer && !cal_status.done;
  assign pipe_xfer = in_xfer && cal_status.done;

  alp_calib #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_calib (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (cal_xfer),
    .sample_i (sample_in.sample),
    .status_o (cal_status)
  );

  // Stage 1: excess over the baseline, gated by the threshold and clamped.
  logic [SampleW-1:0] excess;
  logic [DiffW-1:0]   level_d, level_q;

  always_comb begin
    excess  = sample_in.sample - cal_status.baseline;
    level_d = '0;
    if (sample_in.sample > cal_status.baseline && excess > thresh_q) begin
      level_d = (excess > MaxDiff) ? DiffW'(MAX_LEVEL_DIFF) : excess[DiffW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && pipe_xfer) begin
      level_q <= level_d;
    end
  end

  // Stage 2: logarithmic brightness lookup.
  logic [LevelW-1:0] bright;

  alp_log_rom #(
    .MAX_LEVEL_DIFF (MAX_LEVEL_DIFF)
  ) u_log_rom (
    .clk_i  (clk_i),
    .en_i   (adv2 && v1_q),
    .addr_i (level_q),
    .data_o (bright)
  );

  // Stage 3: smoothing, level = (level*7 + brightness) / 8. The smoothed level
  // register doubles as the pwm_level output register.
  logic [LevelW+2:0] smooth_sum;
  logic [LevelW-1:0] smooth_q;
  logic [LevelW-1:0] inst_q;

  assign smooth_sum = ({3'b000, smooth_q} << 3) - {3'b000, smooth_q}
                      + {3'b000, bright};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= '0;
    end else if (adv3 && v2_q) begin
      smooth_q <= smooth_sum[LevelW+2:3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3 && v2_q) begin
      inst_q <= bright;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= pipe_xfer;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign result_out.valid              = v3_q;
  assign result_out.pwm_level          = smooth_q;
  assign result_out.instant_brightness = inst_q;

`ifndef ASSERT_OFF
  // No result can leave before the baseline exists.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q || v2_q || v3_q) |-> cal_status.done)
    else $error("result in flight before calibration finished");

  // No sample is taken while the baseline is being formed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_status.busy |-> !sample_in.ready)
    else $error("sample accepted during baseline computation");

  // The ROM address never exceeds the clamp.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (level_q <= DiffW'(MAX_LEVEL_DIFF)))
    else $error("level beyond clamp");

  // The baseline is formed only after the transfer that completes calibration.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cal_status.busy) |-> $past(cal_xfer))
    else $error("baseline computation started without a sample transfer");
`endif

endmodule

FILE: hdl/alp_calib.sv
// Calibration unit: sums the first samples, then divides the sum by the
// sample count with one reciprocal multiplication to form the baseline.
// Depends on alp_pkg.
module alp_calib import alp_pkg::*; #(
  parameter int unsigned CAL_SAMPLES = CalSamplesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  logic [SampleW-1:0] sample_i,
  output cal_status_t        status_o
);

  localparam int unsigned CntW   = $clog2(CAL_SAMPLES + 1);
  localparam int unsigned SumW   = SampleW + CntW;
  localparam int unsigned RecipW = SumW + 1;
  localparam int unsigned ProdW  = SumW + RecipW;
  localparam int unsigned Shift  = SumW + $clog2(CAL_SAMPLES);

  // ceil(2^Shift / CAL_SAMPLES) gives the exact truncated quotient for any
  // sum that fits in SumW bits.
  localparam logic [63:0] RecipWide =
    ((64'd1 << Shift) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
  localparam logic [RecipW-1:0] Recip     = RecipW'(RecipWide);
  localparam logic [CntW-1:0]   CountLast = CntW'(CAL_SAMPLES - 1);

  typedef enum logic [2:0] {
    CAL_ACC  = 3'b001,
    CAL_DIV  = 3'b010,
    CAL_DONE = 3'b100
  } cal_state_e;

  cal_state_e         state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [SampleW-1:0] baseline_q, baseline_d;
  logic [ProdW-1:0]   prod;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    sum_d      = sum_q;
    baseline_d = baseline_q;
    prod       = ProdW'(sum_q) * ProdW'(Recip);
    case (state_q)
      CAL_ACC: begin
        if (acc_i) begin
          sum_d = sum_q + SumW'(sample_i);
          if (count_q == CountLast) begin
            state_d = CAL_DIV;
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
      end
      CAL_DIV: begin
        baseline_d = prod[Shift +: SampleW];
        state_d    = CAL_DONE;
      end
      CAL_DONE: begin
        state_d = CAL_DONE;
      end
      default: begin
        state_d = CAL_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= CAL_ACC;
      count_q    <= '0;
      sum_q      <= '0;
      baseline_q <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      sum_q      <= sum_d;
      baseline_q <= baseline_d;
    end
  end

  assign status_o.done     = (state_q == CAL_DONE);
  assign status_o.busy     = (state_q == CAL_DIV);
  assign status_o.baseline = baseline_q;

endmodule

FILE: hdl/alp_log_rom.sv
// Logarithmic brightness ROM with a registered read port, built at elaboration.
// Depends on alp_pkg for the fixed-point log2 and division helpers.
module alp_log_rom import alp_pkg::*; #(
  parameter int unsigned MAX_LEVEL_DIFF = MaxLevelDiffDef
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [$clog2(MAX_LEVEL_DIFF + 1)-1:0] addr_i,
  output logic [LevelW-1:0]                     data_o
);

  localparam int unsigned Depth = MAX_LEVEL_DIFF + 1;

  // Entry d holds floor(65535 * log2(d+1) / log2(MAX+1)); a quotient that sits
  // just below the next integer is rounded up so exact ratios stay exact.
  function automatic logic [Depth*LevelW-1:0] build_rom();
    logic [Depth*LevelW-1:0] bits;
    logic [63:0]             den;
    logic [63:0]             num;
    logic [127:0]            qr;
    logic [63:0]             quo;
    logic [63:0]             rem;
    bits = '0;
    den  = alp_log2_fixed(32'(MAX_LEVEL_DIFF + 1));
    for (int d = 0; d < Depth; d++) begin
      num = 64'(64'(FullScale) * alp_log2_fixed(32'(d + 1)));
      qr  = alp_udiv64(num, den);
      quo = qr[127:64];
      rem = qr[63:0];
      if ((den - rem) <= (den >> 24)) begin
        quo = quo + 64'd1;
      end
      if (quo > 64'(FullScale)) begin
        quo = 64'(FullScale);
      end
      bits[d*LevelW +: LevelW] = quo[LevelW-1:0];
    end
    return bits;
  endfunction

  localparam logic [Depth*LevelW-1:0] RomBits = build_rom();

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_o <= RomBits[addr_i*LevelW +: LevelW];
    end
  end

endmodule

FILE: tb/sv/tb_audio_level_to_pwm_unit.sv
// Self-checking testbench for audio_level_to_pwm_unit: calibration, threshold gating,
// log brightness lookup and smoothing are checked against an in-bench predictor.
// Depends on alp_pkg and the alp_sample_if, alp_result_if and alp_cfg_if interfaces.
module tb_audio_level_to_pwm_unit;
  import alp_pkg::*;

  localparam int unsigned CalSamples   = CalSamplesDef;
  localparam int unsigned MaxLevelDiff = MaxLevelDiffDef;

  // Pipeline depth plus the baseline computation, with a wide margin.
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned CycleLimit   = 200_000;

  typedef struct packed {
    logic [LevelW-1:0] pwm_level;
    logic [LevelW-1:0] instant_brightness;
  } level_pair_t;

  logic clk_i;
  logic rst_ni;

  alp_sample_if sample_if ();
  alp_result_if result_if ();
  alp_cfg_if    cfg_if ();

  audio_level_to_pwm_unit #(
    .CAL_SAMPLES   (CalSamples),
    .MAX_LEVEL_DIFF(MaxLevelDiff)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_in (sample_if),
    .result_out(result_if),
    .cfg_in    (cfg_if)
  );

  // Predictor state: a private copy of everything the block keeps.
  logic [24:0]        cal_sum;
  logic [12:0]        cal_count;
  logic [SampleW-1:0] baseline_q;
  logic               calibrated_q;
  logic [LevelW-1:0]  smoothed_q;
  logic [ThreshW-1:0] threshold_q;

  level_pair_t expected_levels[$];
  int unsigned mismatches;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a correct run ends far below this many cycles.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [SampleW-1:0] clamp_sample(input int value);
    if (value < 0) return '0;
    if (value > (1 << SampleW) - 1) return '1;
    return SampleW'(value);
  endfunction

  // Brightness for a gated level: floor(65535 * log2(d+1) / log2(MaxLevelDiff+1))
  // from fixed-point logarithms, where a quotient within 2^-24 below the next
  // integer counts as that integer.
  function automatic logic [LevelW-1:0] log_brightness(input int unsigned lvl);
    longint unsigned den;
    longint unsigned num;
    longint unsigned quo;
    longint unsigned rem;
    den = alp_log2_fixed(32'(MaxLevelDiff + 1));
    num = 64'(FullScale) * alp_log2_fixed(32'(lvl + 1));
    quo = num / den;
    rem = num % den;
    if ((den - rem) <= (den >> 24)) quo = quo + 1;
    if (quo > 64'(FullScale)) quo = 64'(FullScale);
    return LevelW'(quo);
  endfunction

  // Advances the predictor by one accepted sample and queues the result it causes.
  task automatic predict_sample(input logic [SampleW-1:0] value);
    int unsigned excess;
    int unsigned lvl;
    level_pair_t res;
    if (!calibrated_q) begin
      // Calibration samples, including the one that completes it, give no result.
      cal_sum   = cal_sum + value;
      cal_count = cal_count + 13'd1;
      if (cal_count >= CalSamples) begin
        baseline_q   = SampleW'(cal_sum / CalSamples);
        calibrated_q = 1'b1;
      end
      return;
    end
    lvl = 0;
    if (value > baseline_q) begin
      excess = value - baseline_q;
      if (excess > threshold_q) lvl = (excess > MaxLevelDiff) ? MaxLevelDiff : excess;
    end
    res.instant_brightness = log_brightness(lvl);
    smoothed_q = LevelW'((32'(smoothed_q) * 7 + 32'(res.instant_brightness)) / 8);
    res.pwm_level = smoothed_q;
    expected_levels.push_back(res);
  endtask

  // One sample transfer. Valid is only lowered by the idle loop or by a drain, so it
  // never gets two assignments in the same time step.
  task automatic send_sample(input logic [SampleW-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid  <= 1'b1;
    sample_if.sample <= value;
    do @(posedge clk_i); while (!sample_if.ready);
    predict_sample(value);
  endtask

  // Holds the sender until every expected result has arrived, then lets the block
  // finish any calibration work that produces no result.
  task automatic drain_results();
    sample_if.valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Call only while the block is idle.
  task automatic write_threshold(input logic [ThreshW-1:0] value);
    cfg_if.valid        <= 1'b1;
    cfg_if.excess_limit <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    threshold_q = value;
  endtask

  // Mostly samples around the useful window above the baseline, some from anywhere.
  function automatic logic [SampleW-1:0] pick_sample();
    if ($urandom_range(99) < 75)
      return clamp_sample(int'(baseline_q) - 150 + int'($urandom_range(2300)));
    return SampleW'($urandom_range((1 << SampleW) - 1));
  endfunction

  // Result side: checks each transfer against the oldest expectation and stalls
  // at the current rate.
  always @(posedge clk_i) begin : result_check
    level_pair_t want;
    if (result_if.valid && result_if.ready) begin
      if (expected_levels.size() == 0) begin
        report_mismatch($sformatf("unexpected result pwm_level=%0d instant_brightness=%0d",
                                  result_if.pwm_level, result_if.instant_brightness));
      end else begin
        want = expected_levels.pop_front();
        if (result_if.pwm_level !== want.pwm_level)
          report_mismatch($sformatf("pwm_level got %0d, want %0d",
                                    result_if.pwm_level, want.pwm_level));
        if (result_if.instant_brightness !== want.instant_brightness)
          report_mismatch($sformatf("instant_brightness got %0d, want %0d",
                                    result_if.instant_brightness, want.instant_brightness));
      end
    end
    result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Both sample extremes first so every input bit toggles, then a quiet floor
  // that puts the baseline near a quarter of full scale. Nothing comes out.
  task automatic test_calibration();
    send_sample('0);
    send_sample('1);
    for (int i = 2; i < CalSamples; i++) send_sample(SampleW'($urandom_range(2047)));
    drain_results();
  endtask

  // Gating edges around the baseline with the reset threshold, then the
  // threshold extremes.
  task automatic test_level_gating();
    int base;
    base = int'(baseline_q);
    send_sample('0);                            // far below the baseline
    send_sample(clamp_sample(base - 1));        // just below
    send_sample(clamp_sample(base));            // zero excess
    send_sample(clamp_sample(base + 1000));     // equal to the threshold, still gated
    send_sample(clamp_sample(base + 1001));     // first level that passes
    send_sample(clamp_sample(base + 1500));
    send_sample(clamp_sample(base + MaxLevelDiff));       // top of the ROM
    send_sample(clamp_sample(base + MaxLevelDiff + 1));   // saturates
    repeat (3) send_sample('1);                 // smoothing climbs
    send_sample('0);                            // and decays
    drain_results();
    write_threshold('0);
    send_sample(clamp_sample(base + 1));        // smallest excess passes now
    send_sample(clamp_sample(base + 2));
    send_sample(clamp_sample(base));
    send_sample('1);
    drain_results();
    write_threshold('1);
    send_sample('1);                            // nothing can exceed this threshold
    send_sample(clamp_sample(base + MaxLevelDiff + 1));
  endtask

  task automatic test_random_stream(input int unsigned count, input int unsigned send_pct,
                                    input int unsigned recv_pct,
                                    input logic [ThreshW-1:0] threshold);
    drain_results();
    write_threshold(threshold);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) send_sample(pick_sample());
  endtask

  initial begin : stimulus
    sample_if.valid     <= 1'b0;
    sample_if.sample    <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.excess_limit <= '0;
    rst_ni              <= 1'b0;

    cal_sum        = '0;
    cal_count      = '0;
    baseline_q     = '0;
    calibrated_q   = 1'b0;
    smoothed_q     = '0;
    threshold_q    = ThresholdReset;
    mismatches     = 0;
    send_idle_pct  = 6;
    recv_stall_pct = 58;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_calibration();
    test_level_gating();
    test_random_stream(400, 6, 58, ThresholdReset);
    test_random_stream(400, 58, 6, ThreshW'($urandom_range(300)));
    test_random_stream(400, 0, 0, ThreshW'($urandom_range(1800, 300)));
    drain_results();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
